@@ hw/rtl/surge_cast_burstiness_switch_top_defines.svh @@
// Assertion macros for the surge-cast burstiness switch checker.
// Each macro expects signals named clock and reset in the using scope.
`ifndef SURGE_CAST_BURSTINESS_SWITCH_TOP_DEFINES_SVH
`define SURGE_CAST_BURSTINESS_SWITCH_TOP_DEFINES_SVH

// same-cycle implication
`define SCB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scb check failed: same-cycle rule");

// next-cycle implication
`define SCB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scb check failed: next-cycle rule");

`endif

@@ hw/rtl/scb_pkg.sv @@
// Shared types and constants of the surge-cast burstiness switch.
// No dependencies; imported by every module of the block.
package scb_pkg;

   localparam int TICK_W = 16;
   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   // register indexes on the csr port
   localparam logic [2:0] CSR_CAST_ONE   = 3'd0;
   localparam logic [2:0] CSR_CAST_TWO   = 3'd1;
   localparam logic [2:0] CSR_CAST_THREE = 3'd2;
   localparam logic [2:0] CSR_CAST_FOUR  = 3'd3;
   localparam logic [2:0] CSR_RELEASE    = 3'd4;

   // register reset values
   localparam logic [TICK_W-1:0] CAST_ONE_RST   = 16'd700;
   localparam logic [TICK_W-1:0] CAST_TWO_RST   = 16'd1200;
   localparam logic [TICK_W-1:0] CAST_THREE_RST = 16'd1900;
   localparam logic [TICK_W-1:0] CAST_FOUR_RST  = 16'd2600;
   localparam logic [TICK_W-1:0] RELEASE_RST    = 16'd10000;

   // phase codes as reported on the result channel
   localparam logic [2:0] CODE_STOP  = 3'd0;
   localparam logic [2:0] CODE_SURGE = 3'd1;
   localparam logic [2:0] CODE_CAST1 = 3'd2;
   localparam logic [2:0] CODE_CAST2 = 3'd3;
   localparam logic [2:0] CODE_CAST3 = 3'd4;
   localparam logic [2:0] CODE_CAST4 = 3'd5;

   // drive constants
   localparam logic [6:0] SPEED_STOP  = 7'd0;
   localparam logic [6:0] SPEED_SURGE = 7'd100;
   localparam logic [6:0] SPEED_CAST  = 7'd80;
   localparam logic signed [10:0] RATE_STOP  = 11'sd0;
   localparam logic signed [10:0] RATE_SURGE = 11'sd62;
   localparam logic signed [10:0] RATE_CAST  = 11'sd600;

   // tracker phase, one-hot
   typedef enum logic [5:0] {
      PH_STOP  = 6'b000001,
      PH_SURGE = 6'b000010,
      PH_CAST1 = 6'b000100,
      PH_CAST2 = 6'b001000,
      PH_CAST3 = 6'b010000,
      PH_CAST4 = 6'b100000
   } phase_type;

   // per-tick result fields travelling down the test pipeline
   typedef struct packed {
      logic [2:0]         phase_code;
      logic [6:0]         speed;
      logic signed [10:0] rate;
      logic               rel_ge;   // elapsed count reached the release register
   } item_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      case (ph)
         PH_SURGE: code = CODE_SURGE;
         PH_CAST1: code = CODE_CAST1;
         PH_CAST2: code = CODE_CAST2;
         PH_CAST3: code = CODE_CAST3;
         PH_CAST4: code = CODE_CAST4;
         default:  code = CODE_STOP;
      endcase
      return code;
   endfunction

endpackage

@@ hw/rtl/scb_cell.sv @@
// One cell of the interval history chain: holds one interval and hands it
// to the next cell on every push. Depends on scb_pkg.
module scb_cell
   import scb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic [TICK_W-1:0] din,
   output logic [TICK_W-1:0] dout
);

   logic [TICK_W-1:0] val_ff;
   logic [TICK_W-1:0] val_in;

   // take the neighbor's value on a push
   assign val_in = shift ? din : val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         val_ff <= val_in;
      end
   end

   assign dout = val_ff;

endmodule

@@ hw/rtl/scb_burst.sv @@
// Burstiness test pipeline: squares, running square sum, products, compare.
// Three stages with per-stage valid and backpressure. Depends on scb_pkg.
module scb_burst
   import scb_pkg::*;
#(
   parameter int HISTORY = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic                               push,
   input  logic [TICK_W-1:0]                  new_val,
   input  logic [TICK_W-1:0]                  old_val,
   input  logic [TICK_W+$clog2(HISTORY)-1:0]  sum,
   input  item_type                           item,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic                               fire,
   output item_type                           out_item
);

   localparam int SUM_W = TICK_W + $clog2(HISTORY);
   localparam int SQ1_W = 2 * TICK_W;
   localparam int SQ_W  = SQ1_W + $clog2(HISTORY);
   localparam int K9H   = 9 * HISTORY;
   localparam int LHS_W = SQ_W + $clog2(K9H + 1);
   localparam int RHS_W = 2 * SUM_W + 4;
   localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

   // stage 2: squares of the pushed and dropped intervals
   logic             v2_ff, v2_in;
   logic             push2_ff;
   logic [SQ1_W-1:0] sqn2_ff, sqo2_ff;
   logic [SUM_W-1:0] sum2_ff;
   item_type         item2_ff;

   // stage 3: running square sum
   logic             v3_ff, v3_in;
   logic [SQ_W-1:0]  sqsum_ff, sqsum_in;
   logic [SUM_W-1:0] sum3_ff;
   item_type         item3_ff;

   // stage 4: both sides of the test
   logic             v4_ff, v4_in;
   logic [LHS_W-1:0] lhs_ff;
   logic [RHS_W-1:0] rhs_ff;
   item_type         item4_ff;

   logic free2, free3, free4;
   logic load2, load3, load4;

   // backpressure chain
   assign free4 = !v4_ff || out_ready;
   assign free3 = !v3_ff || free4;
   assign free2 = !v2_ff || free3;
   assign load2 = in_valid && free2;
   assign load3 = v2_ff && free3;
   assign load4 = v3_ff && free4;
   assign in_ready = free2;

   assign v2_in = free2 ? in_valid : v2_ff;
   assign v3_in = free3 ? v2_ff : v3_ff;
   assign v4_in = free4 ? v3_ff : v4_ff;

   // drop the oldest square first so the sum never underflows
   always_comb begin
      sqsum_in = sqsum_ff;
      if (load3 && push2_ff) begin
         sqsum_in = sqsum_ff - SQ_W'(sqo2_ff) + SQ_W'(sqn2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         sqsum_ff <= '0;
      end else begin
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
         sqsum_ff <= sqsum_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load2) begin
         push2_ff <= push;
         sqn2_ff  <= SQ1_W'(new_val) * SQ1_W'(new_val);
         sqo2_ff  <= SQ1_W'(old_val) * SQ1_W'(old_val);
         sum2_ff  <= sum;
         item2_ff <= item;
      end
      if (load3) begin
         sum3_ff  <= sum2_ff;
         item3_ff <= item2_ff;
      end
      if (load4) begin
         // 9 * N * sum(x^2) against 10 * sum(x)^2
         lhs_ff   <= LHS_W'(sqsum_ff) * LHS_W'(K9H);
         rhs_ff   <= RHS_W'(sum3_ff) * RHS_W'(sum3_ff) * RHS_W'(10);
         item4_ff <= item3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign fire      = CMP_W'(lhs_ff) < CMP_W'(rhs_ff);
   assign out_item  = item4_ff;

endmodule

@@ hw/rtl/surge_cast_burstiness_switch_top.sv @@
// A result passes stage 1, the scb_burst stages and the output register before it
// shows on rsp_tvalid. Throughput: one tick per cycle while rsp_tready keeps up;
// the counter/phase update is registered directly and the test pipelines behind it.
// Reset (synchronous, active high) clears counter, phase, sums, history chain
// and reactive flag and reloads the register defaults; no clearing pass.
// Depends on scb_pkg, scb_cell and scb_burst.
module surge_cast_burstiness_switch_top
   import scb_pkg::*;
#(
   parameter int HISTORY = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel; tdata: [0] gas_hit, [1] random_bit, [7:2] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // result channel; tdata: [2:0] moth_phase, [3] reactive_mode,
   // [4] switch_event, [11:5] linear_speed_mm, [22:12] angular_rate_mrad,
   // [23] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int SUM_W = TICK_W + $clog2(HISTORY);

   // configuration registers
   logic [TICK_W-1:0] cast_one_ff, cast_two_ff, cast_three_ff, cast_four_ff;
   logic [TICK_W-1:0] release_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cast_one_ff   <= CAST_ONE_RST;
         cast_two_ff   <= CAST_TWO_RST;
         cast_three_ff <= CAST_THREE_RST;
         cast_four_ff  <= CAST_FOUR_RST;
         release_ff    <= RELEASE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAST_ONE:   cast_one_ff   <= csr_data;
            CSR_CAST_TWO:   cast_two_ff   <= csr_data;
            CSR_CAST_THREE: cast_three_ff <= csr_data;
            CSR_CAST_FOUR:  cast_four_ff  <= csr_data;
            CSR_RELEASE:    release_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // tracker state
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;
   phase_type         phase_ff, phase_in;
   logic              side_ff, side_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   logic              accept, hit, rnd, push;
   logic [TICK_W-1:0] count;
   logic [TICK_W-1:0] hist [HISTORY];
   logic [TICK_W-1:0] oldest;
   item_type          item_in;

   assign accept = req_tvalid && req_tready;
   assign hit    = req_tdata[0];
   assign rnd    = req_tdata[1];
   assign push   = accept && hit;
   assign oldest = hist[HISTORY-1];
   assign count  = (elapsed_ff == TICK_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   // interval history chain
   for (genvar k = 0; k < HISTORY; k++) begin : g_cell
      scb_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (push),
         .din   ((k == 0) ? count : hist[(k == 0) ? 0 : k - 1]),
         .dout  (hist[k])
      );
   end

   // next state; cast checks run in order and may chain in one tick
   always_comb begin
      elapsed_in = elapsed_ff;
      phase_in   = phase_ff;
      side_in    = side_ff;
      sum_in     = sum_ff;
      if (accept) begin
         if (hit) begin
            elapsed_in = '0;
            phase_in   = PH_SURGE;
            side_in    = rnd;
            sum_in     = sum_ff - SUM_W'(oldest) + SUM_W'(count);
         end else begin
            elapsed_in = count;
            if (phase_in == PH_SURGE && count >= cast_one_ff)   phase_in = PH_CAST1;
            if (phase_in == PH_CAST1 && count >= cast_two_ff)   phase_in = PH_CAST2;
            if (phase_in == PH_CAST2 && count >= cast_three_ff) phase_in = PH_CAST3;
            if (phase_in == PH_CAST3 && count >= cast_four_ff)  phase_in = PH_CAST4;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         phase_ff   <= PH_STOP;
         side_ff    <= 1'b0;
         sum_ff     <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         phase_ff   <= phase_in;
         side_ff    <= side_in;
         sum_ff     <= sum_in;
      end
   end

   // drive codes follow the new phase
   always_comb begin
      item_in.phase_code = phase_code(phase_in);
      item_in.rel_ge     = elapsed_in >= release_ff;
      case (phase_in)
         PH_SURGE: begin
            item_in.speed = SPEED_SURGE;
            item_in.rate  = RATE_SURGE;
         end
         PH_CAST1, PH_CAST3: begin
            item_in.speed = SPEED_CAST;
            item_in.rate  = side_in ? -RATE_CAST : RATE_CAST;
         end
         PH_CAST2, PH_CAST4: begin
            item_in.speed = SPEED_CAST;
            item_in.rate  = side_in ? RATE_CAST : -RATE_CAST;
         end
         default: begin
            item_in.speed = SPEED_STOP;
            item_in.rate  = RATE_STOP;
         end
      endcase
   end

   // stage 1: hand the tick to the test pipeline
   logic              v1_ff, v1_in, free1, b_ready;
   logic              push1_ff;
   logic [TICK_W-1:0] new1_ff, old1_ff;
   logic [SUM_W-1:0]  sum1_ff;
   item_type          item1_ff;

   assign free1      = !v1_ff || b_ready;
   assign req_tready = free1;
   assign v1_in      = free1 ? req_tvalid : v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         push1_ff <= hit;
         new1_ff  <= count;
         old1_ff  <= oldest;
         sum1_ff  <= sum_in;
         item1_ff <= item_in;
      end
   end

   logic     b_valid, b_fire, free_out;
   item_type b_item;

   scb_burst #(
      .HISTORY (HISTORY)
   ) u_burst (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_ready  (b_ready),
      .push      (push1_ff),
      .new_val   (new1_ff),
      .old_val   (old1_ff),
      .sum       (sum1_ff),
      .item      (item1_ff),
      .out_valid (b_valid),
      .out_ready (free_out),
      .fire      (b_fire),
      .out_item  (b_item)
   );

   // output register and reactive mode
   logic               out_v_ff, out_v_in, load_out;
   logic               react_ff, react_in;
   logic [2:0]         out_phase_ff;
   logic               out_react_ff, out_fire_ff;
   logic [6:0]         out_speed_ff;
   logic signed [10:0] out_rate_ff;

   assign free_out = !out_v_ff || rsp_tready;
   assign load_out = b_valid && free_out;
   assign out_v_in = free_out ? b_valid : out_v_ff;

   always_comb begin
      react_in = react_ff;
      if (load_out) begin
         if (b_fire) begin
            react_in = 1'b1;
         end else if (react_ff && b_item.rel_ge) begin
            react_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         react_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         react_ff <= react_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_phase_ff <= b_item.phase_code;
         out_react_ff <= react_in;
         out_fire_ff  <= b_fire;
         out_speed_ff <= b_item.speed;
         out_rate_ff  <= b_item.rate;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {1'b0, out_rate_ff, out_speed_ff, out_fire_ff, out_react_ff,
                        out_phase_ff};

endmodule

@@ hw/rtl/surge_cast_burstiness_switch_checker.sv @@
// Port-level checks of the surge-cast burstiness switch, bound to the top.
// Depends on scb_pkg and surge_cast_burstiness_switch_top_defines.svh.
`include "surge_cast_burstiness_switch_top_defines.svh"

module surge_cast_burstiness_switch_checker
   import scb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // result fields
   logic [2:0]  rsp_phase;
   logic        rsp_react;
   logic        rsp_fire;
   logic [6:0]  rsp_speed;
   logic [10:0] rsp_rate;
   logic        drive_stop;
   logic        drive_surge;

   assign rsp_phase   = rsp_tdata[2:0];
   assign rsp_react   = rsp_tdata[3];
   assign rsp_fire    = rsp_tdata[4];
   assign rsp_speed   = rsp_tdata[11:5];
   assign rsp_rate    = rsp_tdata[22:12];
   assign drive_stop  = rsp_speed == SPEED_STOP && rsp_rate == RATE_STOP;
   assign drive_surge = rsp_speed == SPEED_SURGE && rsp_rate == RATE_SURGE;

   // stalled result holds
   `SCB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a switch event always leaves the block in reactive mode
   `SCB_ASSERT_NOW(a_switch_reactive, rsp_tvalid && rsp_fire, rsp_react)

   // stopped phase drives nothing
   `SCB_ASSERT_NOW(a_stop_drive, rsp_tvalid && rsp_phase == CODE_STOP, drive_stop)

   // surge drives at surge speed and surge turn rate
   `SCB_ASSERT_NOW(a_surge_drive, rsp_tvalid && rsp_phase == CODE_SURGE, drive_surge)

endmodule

bind surge_cast_burstiness_switch_top surge_cast_burstiness_switch_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
